// ===== rtl/bfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfs_pkg
// shared types and constants of the bounded fifo with statistics
// ----------------------------------------------------------------------------
package bfs_pkg;

    localparam int DEFAULT_DEPTH      = 64;
    localparam int DEFAULT_DATA_WIDTH = 32;
    localparam int CAP_RESET          = 64;
    localparam int TOTAL_W            = 32;
    localparam int APB_DATA_W         = 32;
    localparam int APB_ADDR_W         = 3;

    typedef enum logic [1:0] {
        REQ_ENQ   = 2'd0,
        REQ_DEQ   = 2'd1,
        REQ_CLOSE = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_CLOSED = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        REG_CAPACITY = 1'b0,
        REG_NONE     = 1'b1
    } t_reg_idx;

endpackage
`default_nettype wire

// ===== rtl/bounded_fifo_with_stats_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_fifo_with_stats_top
// circular fifo with programmable capacity, close/drain and running statistics
//
//   channel   | handshake                          | payload
//   ----------+------------------------------------+------------------------------
//   request   | start, busy                        | i_req_type, i_write_data
//   result    | o_done (one-cycle strobe)          | o_status .. o_high_water
//   config    | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// one request per cycle; busy stays low after reset.
// the result appears in the cycle after the request is taken, as the slot
// memory has a registered read port.
// reset clears pointers, counts, flags and totals; capacity resets to 64, or to DEPTH if smaller.
// the slot memory is not cleared; results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module bounded_fifo_with_stats_top #(
    parameter int DEPTH      = bfs_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = bfs_pkg::DEFAULT_DATA_WIDTH,
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire bfs_pkg::t_req                  i_req_type,
    input  wire logic [DATA_WIDTH-1:0]          i_write_data,
    output logic                                o_done,
    output bfs_pkg::t_status                    o_status,
    output logic [DATA_WIDTH-1:0]               o_read_data,
    output logic [CNT_W-1:0]                    o_occupancy,
    output logic                                o_empty_flag,
    output logic                                o_full_flag,
    output logic                                o_closed_flag,
    output logic [bfs_pkg::TOTAL_W-1:0]         o_enqueue_total,
    output logic [bfs_pkg::TOTAL_W-1:0]         o_dequeue_total,
    output logic [CNT_W-1:0]                    o_high_water,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bfs_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [bfs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bfs_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import bfs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_INIT = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_peak, n_peak;
    logic               r_closed, n_closed;
    logic [TOTAL_W-1:0] r_enq_total, n_enq_total;
    logic [TOTAL_W-1:0] r_deq_total, n_deq_total;
    logic [CNT_W-1:0]   r_cap;
    logic               r_done;
    t_status            r_status, n_status;
    logic               r_deq_ok;
    logic               r_full;

    logic               accept;
    logic               enq_ok;
    logic               deq_ok;
    logic               cfg_write;
    logic [CNT_W-1:0]   eff_cap;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (t_reg_idx'(paddr[2]) == REG_CAPACITY);

    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else if (r_cap > CNT_W'(DEPTH)) begin
            eff_cap = CNT_W'(DEPTH);
        end else begin
            eff_cap = r_cap;
        end
    end

    always_comb begin
        prdata = '0;
        if (t_reg_idx'(paddr[2]) == REG_CAPACITY) begin
            prdata = APB_DATA_W'(r_cap);
        end
    end

    always_comb begin
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_count     = r_count;
        n_closed    = r_closed;
        n_enq_total = r_enq_total;
        n_deq_total = r_deq_total;
        n_status    = ST_OK;
        enq_ok      = 1'b0;
        deq_ok      = 1'b0;
        case (i_req_type)
            REQ_ENQ: begin
                if (r_closed) begin
                    n_status = ST_CLOSED;
                end else if (r_count >= eff_cap) begin
                    n_status = ST_FULL;
                end else begin
                    enq_ok = 1'b1;
                end
            end
            REQ_DEQ: begin
                if (r_count == '0) begin
                    n_status = r_closed ? ST_CLOSED : ST_EMPTY;
                end else begin
                    deq_ok = 1'b1;
                end
            end
            REQ_CLOSE: begin
                n_closed = 1'b1;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
        if (enq_ok) begin
            n_wr_ptr    = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            n_count     = r_count + CNT_W'(1);
            n_enq_total = r_enq_total + TOTAL_W'(1);
        end
        if (deq_ok) begin
            n_rd_ptr    = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            n_count     = r_count - CNT_W'(1);
            n_deq_total = r_deq_total + TOTAL_W'(1);
        end
        n_peak = (n_count > r_peak) ? n_count : r_peak;
    end

    // slot memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (accept && enq_ok) begin
            r_mem[r_wr_ptr] <= i_write_data;
        end
        if (accept && deq_ok) begin
            r_rdata <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_peak      <= '0;
            r_closed    <= 1'b0;
            r_enq_total <= '0;
            r_deq_total <= '0;
            r_cap       <= CNT_W'(CAP_INIT);
            r_done      <= 1'b0;
            r_status    <= ST_OK;
            r_deq_ok    <= 1'b0;
            r_full      <= 1'b0;
        end else begin
            r_done <= accept;
            if (cfg_write) begin
                r_cap <= pwdata[CNT_W-1:0];
            end
            if (accept) begin
                r_rd_ptr    <= n_rd_ptr;
                r_wr_ptr    <= n_wr_ptr;
                r_count     <= n_count;
                r_peak      <= n_peak;
                r_closed    <= n_closed;
                r_enq_total <= n_enq_total;
                r_deq_total <= n_deq_total;
                r_status    <= n_status;
                r_deq_ok    <= deq_ok;
                r_full      <= (n_count >= eff_cap);
            end
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_read_data     = r_deq_ok ? r_rdata : '0;
    assign o_occupancy     = r_count;
    assign o_empty_flag    = (r_count == '0);
    assign o_full_flag     = r_full;
    assign o_closed_flag   = r_closed;
    assign o_enqueue_total = r_enq_total;
    assign o_dequeue_total = r_deq_total;
    assign o_high_water    = r_peak;

    a_done_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept))
        else $error("result strobe without a request");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_peak_covers_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_count)
        else $error("high-water mark below occupancy");

    a_deq_counts_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && deq_ok) |=> (r_deq_total == $past(r_deq_total) + TOTAL_W'(1))
                               && (r_count == $past(r_count) - CNT_W'(1)))
        else $error("dequeue did not update totals and occupancy");

endmodule
`default_nettype wire

// ===== tb/tb_bounded_fifo_with_stats_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_fifo_with_stats_top
// self-checking bench for the bounded fifo with statistics
//
// requests go in over the start/busy handshake with random idle gaps; a
// local copy of the queue state predicts every result, which is checked
// field by field when o_done strobes. capacity is rewritten over the apb
// port between phases, covering zero, one, the built depth and above it.
// directed tests cover data extremes, full and empty, shrinking capacity
// below occupancy, unused request codes and close with drain; a random
// phase runs enqueue and dequeue bursts that fill and drain the queue.
// ----------------------------------------------------------------------------
module tb_bounded_fifo_with_stats_top;
    import bfs_pkg::*;

    localparam int DEPTH       = 64;
    localparam int DW          = 32;
    localparam int CW          = 7;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        t_status         status;
        logic [DW-1:0]   read_data;
        logic [CW-1:0]   occupancy;
        logic            empty_f;
        logic            full_f;
        logic            closed_f;
        logic [31:0]     enq_total;
        logic [31:0]     deq_total;
        logic [CW-1:0]   high_water;
    } t_fifo_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_req                  i_req_type = REQ_NOP;
    logic [DW-1:0]         i_write_data = '0;
    logic                  o_done;
    t_status               o_status;
    logic [DW-1:0]         o_read_data;
    logic [CW-1:0]         o_occupancy;
    logic                  o_empty_flag;
    logic                  o_full_flag;
    logic                  o_closed_flag;
    logic [31:0]           o_enqueue_total;
    logic [31:0]           o_dequeue_total;
    logic [CW-1:0]         o_high_water;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predicted queue state
    logic [DW-1:0] q_slots [0:DEPTH-1];
    logic [5:0]    q_rd_ptr = '0;
    logic [5:0]    q_wr_ptr = '0;
    logic [CW-1:0] q_held = '0;
    logic          q_closed = 1'b0;
    logic [31:0]   q_enq_cnt = '0;
    logic [31:0]   q_deq_cnt = '0;
    logic [CW-1:0] q_peak = '0;
    logic [CW-1:0] q_capacity = 7'(CAP_RESET);

    t_fifo_result awaited_results[$];
    int           error_count = 0;
    int           cycle_count = 0;
    bit           no_gaps = 1'b0;

    bounded_fifo_with_stats_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_write_data    (i_write_data),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_read_data     (o_read_data),
        .o_occupancy     (o_occupancy),
        .o_empty_flag    (o_empty_flag),
        .o_full_flag     (o_full_flag),
        .o_closed_flag   (o_closed_flag),
        .o_enqueue_total (o_enqueue_total),
        .o_dequeue_total (o_dequeue_total),
        .o_high_water    (o_high_water),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[bounded_fifo_with_stats_top] ERROR");
            $finish;
        end
    end

    function automatic logic [CW-1:0] active_capacity();
        if (q_capacity == '0) begin
            return 7'd1;
        end
        if (q_capacity > 7'(DEPTH)) begin
            return 7'(DEPTH);
        end
        return q_capacity;
    endfunction

    function automatic t_fifo_result apply_fifo_request(input t_req req,
                                                        input logic [DW-1:0] data);
        t_fifo_result r;
        logic [CW-1:0] cap;
        cap         = active_capacity();
        r.status    = ST_OK;
        r.read_data = '0;
        case (req)
            REQ_ENQ: begin
                if (q_closed) begin
                    r.status = ST_CLOSED;
                end else if (q_held >= cap) begin
                    r.status = ST_FULL;
                end else begin
                    q_slots[q_wr_ptr] = data;
                    q_wr_ptr          = q_wr_ptr + 6'd1;
                    q_held            = q_held + 7'd1;
                    q_enq_cnt         = q_enq_cnt + 32'd1;
                    if (q_held > q_peak) begin
                        q_peak = q_held;
                    end
                end
            end
            REQ_DEQ: begin
                if (q_held == '0) begin
                    r.status = q_closed ? ST_CLOSED : ST_EMPTY;
                end else begin
                    r.read_data = q_slots[q_rd_ptr];
                    q_rd_ptr    = q_rd_ptr + 6'd1;
                    q_held      = q_held - 7'd1;
                    q_deq_cnt   = q_deq_cnt + 32'd1;
                end
            end
            REQ_CLOSE: begin
                q_closed = 1'b1;
            end
            default: begin
            end
        endcase
        r.occupancy  = q_held;
        r.empty_f    = (q_held == '0);
        r.full_f     = (q_held >= cap);
        r.closed_f   = q_closed;
        r.enq_total  = q_enq_cnt;
        r.deq_total  = q_deq_cnt;
        r.high_water = q_peak;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_fifo_result want;
        if (i_rst_n && o_done) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with no request", 32'(o_status), '0);
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_read_data !== want.read_data)
                    report_mismatch("read_data", o_read_data, want.read_data);
                if (o_occupancy !== want.occupancy)
                    report_mismatch("occupancy", 32'(o_occupancy), 32'(want.occupancy));
                if (o_empty_flag !== want.empty_f)
                    report_mismatch("empty_flag", 32'(o_empty_flag), 32'(want.empty_f));
                if (o_full_flag !== want.full_f)
                    report_mismatch("full_flag", 32'(o_full_flag), 32'(want.full_f));
                if (o_closed_flag !== want.closed_f)
                    report_mismatch("closed_flag", 32'(o_closed_flag), 32'(want.closed_f));
                if (o_enqueue_total !== want.enq_total)
                    report_mismatch("enqueue_total", o_enqueue_total, want.enq_total);
                if (o_dequeue_total !== want.deq_total)
                    report_mismatch("dequeue_total", o_dequeue_total, want.deq_total);
                if (o_high_water !== want.high_water)
                    report_mismatch("high_water", 32'(o_high_water), 32'(want.high_water));
            end
        end
    end

    function automatic int draw_gap();
        return no_gaps ? 0 : int'($urandom_range(0, 11));
    endfunction

    // returns right after the posedge that takes the request
    task automatic send_request(input t_req req, input logic [DW-1:0] data);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_req_type   <= req;
        i_write_data <= data;
        do @(posedge i_clk); while (busy);
        awaited_results.push_back(apply_fifo_request(req, data));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CW-1:0] value);
        wait_idle();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        q_capacity = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_empty_after_reset();
        send_request(REQ_DEQ, 32'hFFFF_FFFF);
        send_request(REQ_NOP, 32'hFFFF_FFFF);
        send_request(REQ_DEQ, 32'h0);
    endtask

    task automatic test_data_extremes();
        send_request(REQ_ENQ, 32'h0000_0000);
        send_request(REQ_ENQ, 32'hFFFF_FFFF);
        send_request(REQ_ENQ, 32'hAAAA_AAAA);
        send_request(REQ_NOP, 32'h5555_5555);
        send_request(REQ_ENQ, 32'h5555_5555);
        repeat (4) send_request(REQ_DEQ, $urandom);
    endtask

    task automatic test_capacity_limits();
        write_capacity(7'd1);
        send_request(REQ_ENQ, $urandom);
        send_request(REQ_ENQ, $urandom);
        send_request(REQ_DEQ, $urandom);
        write_capacity(7'd0);
        send_request(REQ_ENQ, $urandom);
        send_request(REQ_ENQ, $urandom);
        send_request(REQ_DEQ, $urandom);
    endtask

    task automatic test_capacity_shrink();
        write_capacity(7'd64);
        repeat (5) send_request(REQ_ENQ, $urandom);
        write_capacity(7'd2);
        send_request(REQ_ENQ, $urandom);
        repeat (4) send_request(REQ_DEQ, $urandom);
        send_request(REQ_ENQ, $urandom);
        repeat (3) send_request(REQ_DEQ, $urandom);
    endtask

    task automatic test_random_traffic(input int n_items);
        int   sent;
        int   run_len;
        int   pick;
        t_req req;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 5))
                    0:       write_capacity(7'd0);
                    1:       write_capacity(7'd127);
                    2:       write_capacity(7'd64);
                    3:       write_capacity(7'($urandom_range(1, 4)));
                    default: write_capacity(7'($urandom_range(0, 127)));
                endcase
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            run_len = $urandom_range(0, int'(active_capacity()) + 2);
            repeat (run_len) begin
                send_request(REQ_ENQ, $urandom);
                sent++;
            end
            run_len = $urandom_range(0, int'(q_held) + 2);
            repeat (run_len) begin
                send_request(REQ_DEQ, $urandom);
                sent++;
            end
            repeat ($urandom_range(0, 12)) begin
                pick = $urandom_range(0, 19);
                req  = (pick < 9) ? REQ_ENQ : (pick < 18) ? REQ_DEQ : REQ_NOP;
                send_request(req, $urandom);
                if (req != REQ_NOP) begin
                    sent++;
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_close_and_drain();
        int   pick;
        t_req req;
        write_capacity(7'd4);
        repeat (5) send_request(REQ_ENQ, $urandom);
        send_request(REQ_CLOSE, $urandom);
        send_request(REQ_ENQ, $urandom);
        send_request(REQ_CLOSE, $urandom);
        repeat (4) send_request(REQ_DEQ, $urandom);
        send_request(REQ_DEQ, $urandom);
        send_request(REQ_NOP, $urandom);
        send_request(REQ_ENQ, $urandom);
        write_capacity(7'd127);
        repeat (30) begin
            pick = $urandom_range(0, 3);
            req  = t_req'(pick[1:0]);
            send_request(req, $urandom);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_after_reset();
        test_data_extremes();
        test_capacity_limits();
        test_capacity_shrink();
        test_random_traffic(1000);
        test_close_and_drain();
        wait_idle();
        repeat (3) @(posedge i_clk);
        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("[bounded_fifo_with_stats_top] OK");
        end else begin
            $display("[bounded_fifo_with_stats_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== bounded_fifo_with_stats_top.f =====
rtl/bfs_pkg.sv
rtl/bounded_fifo_with_stats_top.sv
tb/tb_bounded_fifo_with_stats_top.sv
